/* rtl/clock_date_field_editor_top_defines.svh */
// ----------------------------------------------------------------------------
// Clock/date field editor assertion macros
// Concurrent assertion wrappers; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CLOCK_DATE_FIELD_EDITOR_TOP_DEFINES_SVH
`define CLOCK_DATE_FIELD_EDITOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CED_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ced assertion failed");
`define CED_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ced assertion failed");
`else
`define CED_ASSERT_IMP(label, ck, rn, ante, cons)
`define CED_ASSERT_NXT(label, ck, rn, ante, cons)
`endif

`endif

/* rtl/ced_pkg.sv */
// ----------------------------------------------------------------------------
// Clock/date field editor package
// Payload types, field limits and cursor codes.
// ----------------------------------------------------------------------------
package ced_pkg;

    localparam int CursorW = 4;
    localparam int ColourW = 3;

    localparam int HourMax    = 23;
    localparam int MinuteMax  = 59;
    localparam int SecondMax  = 59;
    localparam int DayMax     = 31;
    localparam int DayShort   = 30;
    localparam int DayFeb     = 28;
    localparam int DayFebLeap = 29;
    localparam int MonthMax   = 12;
    localparam int YearMax    = 99;
    localparam int WeekdayMax = 7;
    localparam int ColourMax  = 6;

    // cursor codes
    localparam logic [CursorW-1:0] CurNone    = 4'd0;
    localparam logic [CursorW-1:0] CurHour    = 4'd1;
    localparam logic [CursorW-1:0] CurMinute  = 4'd2;
    localparam logic [CursorW-1:0] CurSecond  = 4'd3;
    localparam logic [CursorW-1:0] CurDay     = 4'd4;
    localparam logic [CursorW-1:0] CurMonth   = 4'd5;
    localparam logic [CursorW-1:0] CurYear    = 4'd6;
    localparam logic [CursorW-1:0] CurWeekday = 4'd7;
    localparam logic [CursorW-1:0] CurColour  = 4'd8;

    typedef struct packed {
        logic       btn_prev;
        logic       btn_next;
        logic       btn_down;
        logic       btn_up;
        logic [4:0] hour_in;
        logic [5:0] minute_in;
        logic [5:0] second_in;
        logic [4:0] day_in;
        logic [3:0] month_in;
        logic [6:0] year_in;
        logic [2:0] weekday_in;
    } sample_t;

    typedef struct packed {
        logic [4:0]         hour_out;
        logic [5:0]         minute_out;
        logic [5:0]         second_out;
        logic [4:0]         day_out;
        logic [3:0]         month_out;
        logic [6:0]         year_out;
        logic [2:0]         weekday_out;
        logic               write_clock;
        logic [ColourW-1:0] colour_out;
        logic               write_colour;
        logic [CursorW-1:0] cursor_out;
    } result_t;

endpackage

/* rtl/ced_if.sv */
// ----------------------------------------------------------------------------
// Clock/date field editor channels
// Valid/ready channels for button samples and edit results.
// ----------------------------------------------------------------------------
interface ced_in_if;
    logic             valid;
    logic             ready;
    ced_pkg::sample_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ced_out_if;
    logic             valid;
    logic             ready;
    ced_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ced_edit.sv */
// ----------------------------------------------------------------------------
// Clock/date field editor edit logic
// Cursor move, field wrap and day-of-month fixup for one sample.
// ----------------------------------------------------------------------------
module ced_edit (
    input  ced_pkg::sample_t                item,
    input  logic [ced_pkg::CursorW-1:0]     cursor,
    input  logic [ced_pkg::ColourW-1:0]     colour,
    output ced_pkg::result_t                res
);
    import ced_pkg::*;

    function automatic logic [6:0] wrap_dec(logic [6:0] v, logic [6:0] lo, logic [6:0] hi);
        logic [6:0] r;
        if (v <= lo || v > hi)
            r = hi;
        else
            r = v - 7'd1;
        return r;
    endfunction

    function automatic logic [6:0] wrap_inc(logic [6:0] v, logic [6:0] lo, logic [6:0] hi);
        logic [6:0] r;
        if (v >= hi || v < lo)
            r = lo;
        else
            r = v + 7'd1;
        return r;
    endfunction

    function automatic logic [4:0] month_len(logic [3:0] month, logic [6:0] year);
        logic [4:0] len;
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'(DayShort);
            4'd2:    len = (year[1:0] == 2'b00) ? 5'(DayFebLeap) : 5'(DayFeb);
            default: len = 5'(DayMax);
        endcase
        return len;
    endfunction

    // clamp: overlong day goes to month length, else wraps to 1
    function automatic logic [4:0] fix_day(logic [5:0] day, logic [3:0] month,
                                           logic [6:0] year, logic clamp);
        logic [4:0] len;
        logic [4:0] r;
        len = month_len(month, year);
        if (day == 6'd0)
            r = 5'd1;
        else if (day <= 6'(DayFeb))
            r = day[4:0];
        else if (day > {1'b0, len})
            r = clamp ? len : 5'd1;
        else
            r = day[4:0];
        return r;
    endfunction

    logic [CursorW-1:0] cur;
    logic [ColourW-1:0] col;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [6:0]         year;
    logic [2:0]         wday;
    logic [5:0]         day_dec;
    logic               dn;
    logic               up;
    logic               any_btn;

    always_comb
    begin
        dn      = item.btn_down;
        up      = item.btn_up;
        any_btn = dn || up;
        hour    = item.hour_in;
        minute  = item.minute_in;
        second  = item.second_in;
        day     = item.day_in;
        month   = item.month_in;
        year    = item.year_in;
        wday    = item.weekday_in;
        col     = colour;
        cur     = cursor;
        day_dec = (item.day_in <= 5'd1) ? 6'(DayMax) : ({1'b0, item.day_in} - 6'd1);

        // back first, then forward
        if (item.btn_prev)
            cur = (cur == CurNone) ? CurColour : cur - 4'd1;
        if (item.btn_next)
            cur = (cur == CurColour) ? CurNone : cur + 4'd1;

        case (cur)
            CurHour:
            begin
                if (dn)
                    hour = 5'(wrap_dec(7'(hour), 7'd0, 7'(HourMax)));
                else if (up)
                    hour = 5'(wrap_inc(7'(hour), 7'd0, 7'(HourMax)));
            end
            CurMinute:
            begin
                if (dn)
                    minute = 6'(wrap_dec(7'(minute), 7'd0, 7'(MinuteMax)));
                else if (up)
                    minute = 6'(wrap_inc(7'(minute), 7'd0, 7'(MinuteMax)));
            end
            CurSecond:
            begin
                if (dn)
                    second = 6'(wrap_dec(7'(second), 7'd0, 7'(SecondMax)));
                else if (up)
                    second = 6'(wrap_inc(7'(second), 7'd0, 7'(SecondMax)));
            end
            CurDay:
            begin
                if (dn)
                    day = fix_day(day_dec, month, year, 1'b1);
                else if (up)
                    day = fix_day({1'b0, day} + 6'd1, month, year, 1'b0);
            end
            CurMonth:
            begin
                if (dn)
                    month = 4'(wrap_dec(7'(month), 7'd1, 7'(MonthMax)));
                else if (up)
                    month = 4'(wrap_inc(7'(month), 7'd1, 7'(MonthMax)));
                day = fix_day({1'b0, day}, month, year, 1'b1);
            end
            CurYear:
            begin
                if (dn)
                    year = wrap_dec(year, 7'd0, 7'(YearMax));
                else if (up)
                    year = wrap_inc(year, 7'd0, 7'(YearMax));
                day = fix_day({1'b0, day}, month, year, 1'b1);
            end
            CurWeekday:
            begin
                if (dn)
                    wday = 3'(wrap_dec(7'(wday), 7'd1, 7'(WeekdayMax)));
                else if (up)
                    wday = 3'(wrap_inc(7'(wday), 7'd1, 7'(WeekdayMax)));
            end
            CurColour:
            begin
                if (dn)
                    col = (col == 3'd0) ? 3'(ColourMax) : col - 3'd1;
                else if (up)
                    col = (col >= 3'(ColourMax)) ? 3'd0 : col + 3'd1;
            end
            default:
            begin
            end
        endcase

        res.hour_out     = hour;
        res.minute_out   = minute;
        res.second_out   = second;
        res.day_out      = day;
        res.month_out    = month;
        res.year_out     = year;
        res.weekday_out  = wday;
        res.write_clock  = any_btn && (cur >= CurHour) && (cur <= CurWeekday);
        res.colour_out   = col;
        res.write_colour = any_btn && (cur == CurColour);
        res.cursor_out   = cur;
    end

endmodule

/* rtl/clock_date_field_editor_top.sv */
// An accepted sample is held in the input register; its edit result is then
// written to the result register, from which the result channel takes it.
// Throughput: one sample per cycle when the result is not stalled; input and
// result registers let the edit logic between them take a new beat every cycle.
// A stalled result stalls the input register, then the sample channel.
// Reset (rst_n low, async) clears cursor, colour and both valid flags.
// ----------------------------------------------------------------------------
// Clock/date field editor top level
// Registers a button sample, edits the selected field, registers the result.
// ----------------------------------------------------------------------------
`include "clock_date_field_editor_top_defines.svh"

module clock_date_field_editor_top (
    input  logic      clk,
    input  logic      rst_n,
    ced_in_if.sink    sample,
    ced_out_if.source result
);
    import ced_pkg::*;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    sample_t            s1_item_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_item_reg;
    logic [CursorW-1:0] cursor_reg;
    logic [CursorW-1:0] cursor_next;
    logic [ColourW-1:0] colour_reg;
    logic [ColourW-1:0] colour_next;
    result_t            edit_res;
    logic               out_take;
    logic               s1_ready;
    logic               adv;

    ced_edit u_edit (
        .item   (s1_item_reg),
        .cursor (cursor_reg),
        .colour (colour_reg),
        .res    (edit_res)
    );

    assign out_take     = !out_valid_reg || result.ready;
    assign s1_ready     = !s1_valid_reg || out_take;
    assign adv          = s1_valid_reg && out_take;
    assign sample.ready = s1_ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_item_reg;

    always_comb
    begin
        s1_valid_next  = s1_ready ? sample.valid : s1_valid_reg;
        out_valid_next = out_take ? s1_valid_reg : out_valid_reg;
        // state advances with the beat that moves into the result register
        cursor_next    = adv ? edit_res.cursor_out : cursor_reg;
        colour_next    = adv ? edit_res.colour_out : colour_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cursor_reg    <= CurNone;
            colour_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cursor_reg    <= cursor_next;
            colour_reg    <= colour_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && sample.valid)
            s1_item_reg <= sample.data;
        if (adv)
            out_item_reg <= edit_res;
    end

    `CED_ASSERT_IMP(a_cursor_matches_state, clk, rst_n, result.valid, result.data.cursor_out == cursor_reg)
    `CED_ASSERT_IMP(a_strobes_exclusive, clk, rst_n, result.valid, !(result.data.write_clock && result.data.write_colour))
    `CED_ASSERT_NXT(a_colour_holds, clk, rst_n, !adv, $stable(colour_reg))

endmodule
